/* rtl/akf_pkg.sv */
// Shared types, constants and command structs for the angle Kalman filter.
package akf_pkg;

  // Field and state widths.
  localparam int ANGLE_BITS   = 32;
  localparam int VAR_BITS     = 40;
  localparam int GAIN_BITS    = 32;
  localparam int CFG_BITS     = 40;
  localparam int CFG_IDX_BITS = 2;
  localparam int OP_BITS      = 2;
  localparam int IN_DATA_BITS  = 32;
  localparam int OUT_DATA_BITS = ANGLE_BITS + VAR_BITS + GAIN_BITS;

  // The divider produces one quotient bit per step.
  localparam int DIV_STEPS    = GAIN_BITS;
  localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);
  localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(DIV_STEPS - 1);

  // Register reset values, Q0.40.
  localparam logic [CFG_BITS-1:0] MEAS_VAR_RESET = 40'd2748779069;
  localparam logic [CFG_BITS-1:0] PROC_VAR_RESET = 40'd1099512;
  localparam logic [VAR_BITS-1:0] VAR_MAX        = {VAR_BITS{1'b1}};

  // Register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_MEAS_VAR = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PROC_VAR = 2'd1;

  // Opcodes.
  typedef enum logic [OP_BITS-1:0] {
    OP_RESET   = 2'd0,
    OP_RESTART = 2'd1,
    OP_PREDICT = 2'd2,
    OP_UPDATE  = 2'd3
  } op_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;
    logic exec_simple;
    logic div_step;
    logic mul_lo;
    logic mul_hi;
    logic apply;
    logic out_load;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic is_update;
  } status_t;

endpackage

/* rtl/akf_ctrl.sv */
// Sequencing state machine for the angle Kalman filter.
module akf_ctrl
  import akf_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_DISPATCH = 7'b0000010,
    S_DIV      = 7'b0000100,
    S_MUL_LO   = 7'b0001000,
    S_MUL_HI   = 7'b0010000,
    S_APPLY    = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [DIV_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                    out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  // Next state and command decode.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cnt_nxt = '0;
        if (status.is_update) begin
          state_nxt = S_DIV;
        end else begin
          cmd.exec_simple = 1'b1;
          state_nxt       = S_DONE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + DIV_CNT_BITS'(1);
        if (cnt_r == DIV_LAST) begin
          state_nxt = S_MUL_LO;
        end
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // An accepted item always goes to dispatch next.
  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_DISPATCH))
    else $error("accepted item did not reach dispatch");

  // The divider always starts from step zero.
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DISPATCH && status.is_update) |=> (state_r == S_DIV && cnt_r == '0))
    else $error("divider did not start at step zero");

  // After the last quotient bit the multiplies follow.
  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && cnt_r == DIV_LAST) |=> (state_r == S_MUL_LO))
    else $error("divider ran past its last step");

  // A loaded result is presented on the next cycle.
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (out_tvalid && state_r == S_IDLE))
    else $error("result not presented after load");

endmodule

/* rtl/akf_datapath.sv */
// Estimate, variance, divider and multiplier datapath of the angle Kalman filter.
module akf_datapath
  import akf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  output status_t                  status,
  input  logic [OP_BITS-1:0]       in_opcode,
  input  logic [ANGLE_BITS-1:0]    in_angle,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_BITS-1:0]      cfg_wdata,
  output logic [OUT_DATA_BITS-1:0] out_data
);

  // Configuration registers.
  logic [VAR_BITS-1:0]   meas_var_r, proc_var_r;
  // Filter state.
  logic [ANGLE_BITS-1:0] est_r;
  logic [VAR_BITS-1:0]   var_r;
  // Item and working registers.
  op_t                   op_r;
  logic [ANGLE_BITS-1:0] ang_r;
  logic [ANGLE_BITS-1:0] mag_r;
  logic                  neg_r;
  logic [VAR_BITS:0]     rem_r;
  logic [VAR_BITS:0]     den_r;
  logic [GAIN_BITS-1:0]  gain_r;
  logic [ANGLE_BITS+GAIN_BITS-1:0] prod_r;
  // Output register.
  logic [ANGLE_BITS-1:0] out_ang_r;
  logic [VAR_BITS-1:0]   out_var_r;
  logic [GAIN_BITS-1:0]  out_gain_r;

  logic [ANGLE_BITS-1:0] innov;
  logic [VAR_BITS+1:0]   rem_sh;
  logic                  rem_ge;
  logic [VAR_BITS:0]     pred_sum;
  logic [VAR_BITS-1:0]   var_prod;
  logic [ANGLE_BITS-1:0] corr;

  assign status.is_update = (op_r == OP_UPDATE);
  assign out_data = {out_gain_r, out_var_r, out_ang_r};

  // Wrapped innovation against the current estimate.
  assign innov = in_angle - est_r;

  // One restoring division step.
  assign rem_sh = {rem_r, 1'b0};
  assign rem_ge = (rem_sh >= {1'b0, den_r});

  // Predict sum with one guard bit for saturation.
  assign pred_sum = {1'b0, var_r} + {1'b0, proc_var_r};

  // Upper byte of R times gain plus the carried low partial product.
  assign var_prod = VAR_BITS'({meas_var_r[VAR_BITS-1:ANGLE_BITS]} * gain_r)
                  + VAR_BITS'(prod_r[ANGLE_BITS+GAIN_BITS-1:GAIN_BITS]);

  assign corr = prod_r[ANGLE_BITS+GAIN_BITS-1:GAIN_BITS];

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meas_var_r <= MEAS_VAR_RESET;
      proc_var_r <= PROC_VAR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MEAS_VAR: meas_var_r <= cfg_wdata;
        CFG_PROC_VAR: proc_var_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Filter state updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      est_r <= '0;
      var_r <= PROC_VAR_RESET;
    end else if (cmd.exec_simple) begin
      unique case (op_r)
        OP_RESET: begin
          est_r <= '0;
          var_r <= proc_var_r;
        end
        OP_RESTART: begin
          est_r <= ang_r;
          var_r <= proc_var_r;
        end
        default: begin
          var_r <= pred_sum[VAR_BITS] ? VAR_MAX : pred_sum[VAR_BITS-1:0];
        end
      endcase
    end else if (cmd.mul_hi) begin
      var_r <= var_prod;
    end else if (cmd.apply) begin
      est_r <= neg_r ? (est_r - corr) : (est_r + corr);
    end
  end

  // Item capture, divider and multiplier. The remainder keeps all bits of the
  // denominator, which can exceed the variance width.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= op_t'(in_opcode);
      ang_r  <= in_angle;
      neg_r  <= innov[ANGLE_BITS-1];
      mag_r  <= innov[ANGLE_BITS-1] ? (~innov + ANGLE_BITS'(1)) : innov;
      rem_r  <= {1'b0, var_r};
      den_r  <= {1'b0, var_r} + {1'b0, meas_var_r};
      gain_r <= '0;
    end else if (cmd.div_step) begin
      rem_r  <= rem_ge ? (VAR_BITS+1)'(rem_sh - {1'b0, den_r}) : (VAR_BITS+1)'(rem_sh);
      gain_r <= {gain_r[GAIN_BITS-2:0], rem_ge};
    end
    if (cmd.mul_lo) begin
      prod_r <= {{GAIN_BITS{1'b0}}, meas_var_r[ANGLE_BITS-1:0]}
              * {{ANGLE_BITS{1'b0}}, gain_r};
    end else if (cmd.mul_hi) begin
      prod_r <= {{GAIN_BITS{1'b0}}, mag_r} * {{ANGLE_BITS{1'b0}}, gain_r};
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ang_r  <= est_r;
      out_var_r  <= var_r;
      out_gain_r <= gain_r;
    end
  end

endmodule

/* rtl/angle_kalman_filter.sv */
// Top level of the angle Kalman filter: stream ports, controller and datapath.
//
// One-state Kalman filter for a heading held as a 32-bit binary angle (2^32 is one
// turn). Each input item carries an opcode in in_tuser (reset, restart, predict,
// update) and an angle in in_tdata, and yields exactly one result item with the
// estimate, the Q0.40 variance and the Q0.32 gain (zero unless updating). The block
// works on one item at a time and takes the next item once its result is loaded:
// for reset, restart and predict the item passes from dispatch straight to done;
// for an update the 32-step restoring divider for the gain runs first, followed by
// two 32x32 multiplies and the estimate correction before the result is loaded.
// A new item is accepted while the previous result still waits at the output; its
// own result then waits until the output is free. Registers are written through
// cfg_we/cfg_index/cfg_wdata: index 0 is the measurement variance, index 1 the
// process variance; other indexes are ignored.
module angle_kalman_filter
  import akf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_DATA_BITS-1:0]  in_tdata,   // [31:0] angle_in
  input  logic [OP_BITS-1:0]       in_tuser,   // [1:0] opcode
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DATA_BITS-1:0] out_tdata,  // [31:0] filtered_angle,
                                               // [71:32] covariance_out,
                                               // [103:72] gain_out
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_BITS-1:0]      cfg_wdata
);

  cmd_t    cmd;
  status_t status;

  akf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  akf_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_opcode (in_tuser),
    .in_angle  (in_tdata[ANGLE_BITS-1:0]),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_tdata)
  );

endmodule

/* tb/sv/angle_kalman_filter_checker.sv */
// Stream monitor, angle Kalman filter predictor and result comparator.
module angle_kalman_filter_checker
  import akf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  input  logic                     in_tready,
  input  logic [IN_DATA_BITS-1:0]  in_tdata,   // [31:0] angle_in
  input  logic [OP_BITS-1:0]       in_tuser,   // [1:0] opcode
  input  logic                     out_tvalid,
  input  logic                     out_tready,
  input  logic [OUT_DATA_BITS-1:0] out_tdata,  // [31:0] filtered_angle,
                                               // [71:32] covariance_out,
                                               // [103:72] gain_out
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_BITS-1:0]      cfg_wdata,
  output int                       mismatch_count,
  output int                       results_waiting,
  output int                       results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;
  localparam int PEND_DEPTH   = 16;

  // Same layout as out_tdata, highest field first.
  typedef struct packed {
    logic [GAIN_BITS-1:0]  gain;
    logic [VAR_BITS-1:0]   covariance;
    logic [ANGLE_BITS-1:0] angle;
  } filter_result_t;

  // Predicted filter state and register copies.
  logic [CFG_BITS-1:0]   meas_var;
  logic [CFG_BITS-1:0]   proc_var;
  logic [ANGLE_BITS-1:0] est_angle;
  logic [VAR_BITS-1:0]   est_var;

  // Predicted results in order of acceptance, kept in a ring.
  filter_result_t pend_mem [PEND_DEPTH];
  int             pend_head = 0;
  int             pend_tail = 0;
  int             pend_count = 0;

  filter_result_t predicted;
  filter_result_t want;
  filter_result_t got;
  int             bad_results = 0;
  int             seen_results = 0;

  // Q0.32 quotient num/den by restoring division; all ones when num equals den.
  function automatic logic [GAIN_BITS-1:0] gain_quotient(input logic [VAR_BITS:0] num,
                                                         input logic [VAR_BITS:0] den);
    logic [VAR_BITS+2:0]  rem;
    logic [GAIN_BITS-1:0] quo;
    rem = num;
    quo = '0;
    for (int i = 0; i < GAIN_BITS; i++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= den) begin
        rem    = rem - den;
        quo[0] = 1'b1;
      end
    end
    return quo;
  endfunction

  // floor(value * gain / 2^32)
  function automatic logic [VAR_BITS-1:0] scale_by_gain(input logic [VAR_BITS-1:0]  value,
                                                        input logic [GAIN_BITS-1:0] gain);
    logic [VAR_BITS+GAIN_BITS-1:0] prod;
    prod = value * gain;
    return prod[VAR_BITS+GAIN_BITS-1:GAIN_BITS];
  endfunction

  // Advances the predicted state by one item and returns the result it produces.
  function automatic filter_result_t run_filter(input op_t op,
                                                input logic [ANGLE_BITS-1:0] angle);
    filter_result_t        res;
    logic [VAR_BITS:0]     var_sum;
    logic [ANGLE_BITS-1:0] innov;
    logic [ANGLE_BITS-1:0] innov_mag;
    logic [ANGLE_BITS-1:0] correction;
    logic [GAIN_BITS-1:0]  gain;
    gain = '0;
    case (op)
      OP_RESET: begin
        est_var   = proc_var;
        est_angle = '0;
      end
      OP_RESTART: begin
        est_var   = proc_var;
        est_angle = angle;
      end
      OP_PREDICT: begin
        // Growing variance saturates at full scale.
        var_sum = {1'b0, est_var} + {1'b0, proc_var};
        est_var = var_sum[VAR_BITS] ? VAR_MAX : var_sum[VAR_BITS-1:0];
      end
      OP_UPDATE: begin
        // Wrapped innovation; half a turn reads as negative.
        innov      = angle - est_angle;
        innov_mag  = innov[ANGLE_BITS-1] ? -innov : innov;
        gain       = gain_quotient({1'b0, est_var}, {1'b0, est_var} + {1'b0, meas_var});
        correction = ANGLE_BITS'(scale_by_gain(VAR_BITS'(innov_mag), gain));
        est_angle  = innov[ANGLE_BITS-1] ? est_angle - correction : est_angle + correction;
        est_var    = scale_by_gain(meas_var, gain);
      end
    endcase
    res.angle      = est_angle;
    res.covariance = est_var;
    res.gain       = gain;
    return res;
  endfunction

  // Track registers and items at every edge, compare results in order.
  always @(posedge clk) begin
    if (!rst_n) begin
      meas_var   = MEAS_VAR_RESET;
      proc_var   = PROC_VAR_RESET;
      est_angle  = '0;
      est_var    = PROC_VAR_RESET;
      pend_head  = 0;
      pend_tail  = 0;
      pend_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MEAS_VAR: meas_var = cfg_wdata;
          CFG_PROC_VAR: proc_var = cfg_wdata;
          default: ;
        endcase
      end
      // A result leaving at this edge belongs to an item accepted earlier.
      if (out_tvalid && out_tready) begin
        got = filter_result_t'(out_tdata);
        seen_results++;
        if (pend_count == 0) begin
          bad_results++;
          if (bad_results <= REPORT_LIMIT)
            $display("%0t: result item with nothing pending: angle %h cov %h gain %h",
                     $realtime, got.angle, got.covariance, got.gain);
        end else begin
          want       = pend_mem[pend_head];
          pend_head  = (pend_head + 1) % PEND_DEPTH;
          pend_count--;
          if (got.angle !== want.angle || got.covariance !== want.covariance ||
              got.gain !== want.gain) begin
            bad_results++;
            if (bad_results <= REPORT_LIMIT) begin
              $display("%0t: result item %0d differs", $realtime, seen_results);
              $display("  expected angle %h cov %h gain %h",
                       want.angle, want.covariance, want.gain);
              $display("  actual   angle %h cov %h gain %h",
                       got.angle, got.covariance, got.gain);
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        predicted = run_filter(op_t'(in_tuser), in_tdata);
        if (pend_count == PEND_DEPTH) begin
          bad_results++;
          if (bad_results <= REPORT_LIMIT)
            $display("%0t: more than %0d results pending", $realtime, PEND_DEPTH);
        end else begin
          pend_mem[pend_tail] = predicted;
          pend_tail           = (pend_tail + 1) % PEND_DEPTH;
          pend_count++;
        end
      end
    end
    results_waiting <= pend_count;
    mismatch_count  <= bad_results;
    results_checked <= seen_results;
  end

endmodule

/* tb/sv/angle_kalman_filter_tb.sv */
// Testbench top for the angle Kalman filter: clock, reset, stimulus and verdict.
module angle_kalman_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import akf_pkg::*;

  localparam int RESET_CYCLES  = 8;
  localparam int IDLE_LIMIT    = 5000;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 60;
  localparam int RANDOM_PHASES = 4;
  localparam int PHASE_ITEMS   = 100;

  // Indexes past the register list; writes there are ignored.
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_B = 2'd3;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [IN_DATA_BITS-1:0]  in_tdata = '0;   // [31:0] angle_in
  logic [OP_BITS-1:0]       in_tuser = '0;   // [1:0] opcode
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] out_tdata;       // [31:0] angle, [71:32] cov, [103:72] gain
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_BITS-1:0]      cfg_wdata = '0;

  int                       mismatch_count;
  int                       results_waiting;
  int                       results_checked;

  logic                     hold_request = 1'b0;
  int                       burst_left = 0;
  int                       items_sent = 0;
  int                       updates_sent = 0;
  int                       settings_used = 1;
  logic [ANGLE_BITS-1:0]    heading = '0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  angle_kalman_filter uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  angle_kalman_filter_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatch_count),
    .results_waiting (results_waiting),
    .results_checked (results_checked)
  );

  // Offers one item and returns at the edge that accepts it; bursts end in a random gap.
  task automatic send_item(input op_t op, input logic [ANGLE_BITS-1:0] angle);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= angle;
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (op == OP_UPDATE)
      updates_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stops offering items and waits until every pending result has been taken.
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (results_waiting != 0);
  endtask

  // One register write, issued only while the filter is idle.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_BITS-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Variance setting: full range, a random magnitude, or a small value.
  function automatic logic [CFG_BITS-1:0] pick_variance();
    logic [CFG_BITS-1:0] v;
    v = CFG_BITS'({$urandom, $urandom});
    case ($urandom_range(0, 3))
      0: v = v >> $urandom_range(0, CFG_BITS - 1);
      1: v = v >> $urandom_range(16, 36);
      default: ;
    endcase
    if (v == '0)
      v = 1;
    return v;
  endfunction

  // Mostly a tracked heading with measurement noise, some restarts, resets and noise.
  task automatic send_random_item();
    int                    pick;
    op_t                   op;
    logic [ANGLE_BITS-1:0] angle;
    pick = $urandom_range(0, 99);
    if (pick < 6)
      op = OP_RESET;
    else if (pick < 16)
      op = OP_RESTART;
    else if (pick < 48)
      op = OP_PREDICT;
    else
      op = OP_UPDATE;
    if (op == OP_RESET)
      heading = '0;
    else if (op == OP_RESTART || $urandom_range(0, 9) == 0)
      heading = $urandom;
    else
      heading = heading + ANGLE_BITS'($urandom_range(0, 'hFFFFF)) - 32'h7FFFF;
    if ($urandom_range(0, 4) == 0)
      angle = $urandom;
    else
      angle = heading + ANGLE_BITS'($urandom_range(0, 'h3FFFF)) - 32'h1FFFF;
    send_item(op, angle);
  endtask

  // Receiver: changing ready patterns, plus one long hold-off on request.
  initial begin
    int  mode;
    int  mode_left;
    int  hold_left;
    bit  hold_done;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Watchdog: the run ends if no item moves on either stream and no register is written for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  // Main sequence: directed cases, then random phases under changing registers.
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset register values: angle extremes and wrapping innovations.
    send_item(OP_PREDICT, 32'h0000_0000);
    send_item(OP_UPDATE,  32'h7FFF_FFFF);
    send_item(OP_UPDATE,  32'h8000_0000);
    send_item(OP_RESET,   32'hFFFF_FFFF);
    send_item(OP_UPDATE,  32'h8000_0000);  // exactly half a turn away
    send_item(OP_RESTART, 32'h7FFF_FFFF);
    send_item(OP_UPDATE,  32'h8000_0000);  // wraps across the sign boundary
    send_item(OP_RESTART, 32'h8000_0000);
    send_item(OP_UPDATE,  32'h7FFF_FFFF);
    send_item(OP_RESTART, 32'hFFFF_FFFF);
    send_item(OP_UPDATE,  32'h0000_0001);
    wait_for_results();

    // Unlisted indexes, then full-scale variances so predict saturates.
    write_reg(CFG_SPARE_A, '1);
    write_reg(CFG_SPARE_B, 40'h55_5555_5555);
    write_reg(CFG_MEAS_VAR, VAR_MAX);
    write_reg(CFG_PROC_VAR, VAR_MAX);
    settings_used++;
    send_item(OP_RESET,   32'h0000_0000);
    send_item(OP_PREDICT, 32'h0000_0000);
    send_item(OP_PREDICT, 32'hAAAA_AAAA);
    send_item(OP_UPDATE,  32'h4000_0000);
    send_item(OP_UPDATE,  32'hC000_0000);
    wait_for_results();

    // Smallest variances: the gain sits at one half.
    write_reg(CFG_MEAS_VAR, 40'd1);
    write_reg(CFG_PROC_VAR, 40'd1);
    settings_used++;
    send_item(OP_RESTART, 32'h1234_5678);
    send_item(OP_UPDATE,  32'h9234_5678);
    send_item(OP_PREDICT, 32'h0000_0000);
    send_item(OP_UPDATE,  32'hEDCB_A987);
    wait_for_results();

    // Zero measurement variance; the variance is already zero, so the first updates see a zero denominator.
    write_reg(CFG_MEAS_VAR, '0);
    settings_used++;
    send_item(OP_UPDATE,  32'h0F0F_0F0F);
    send_item(OP_UPDATE,  32'hF0F0_F0F0);
    send_item(OP_PREDICT, 32'h0000_0000);
    send_item(OP_UPDATE,  32'h8000_0001);
    wait_for_results();

    // Random phases; the second one carries the long receiver hold-off.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if ($urandom_range(0, 1) == 0)
        write_reg(CFG_SPARE_B, pick_variance());
      write_reg(CFG_MEAS_VAR, pick_variance());
      write_reg(CFG_PROC_VAR, pick_variance());
      settings_used++;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 1 && n == 20)
          hold_request <= 1'b1;
        send_random_item();
        if ($urandom_range(0, 49) == 0)
          wait_for_results();
      end
      wait_for_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d items (%0d updates) under %0d register settings,",
             items_sent, updates_sent, settings_used);
    $display("with saturation, zero variances, ignored indexes and a %0d-cycle stall; %0d checked",
             HOLD_CYCLES, results_checked);
    if (mismatch_count == 0 && results_waiting == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d bad results, %0d never arrived", mismatch_count, results_waiting);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
